/* rtl/meu_pkg.sv */
package meu_pkg;

   localparam int unsigned QueueDepth = 2;

   // full opcode bytes
   localparam logic [7:0] CMD_ROLD = 8'h08;
   localparam logic [7:0] CMD_RORD = 8'h09;
   localparam logic [7:0] CMD_INC  = 8'h20;
   localparam logic [7:0] CMD_DEC  = 8'h28;
   localparam logic [7:0] CMD_MCMP = 8'h2f;

   // opcode groups, cmd[7:3]
   localparam logic [4:0] GRP_SET  = 5'h08;
   localparam logic [4:0] GRP_CLR  = 5'h09;
   localparam logic [4:0] GRP_LD   = 5'h0b;
   localparam logic [4:0] GRP_XCH  = 5'h15;
   localparam logic [4:0] GRP_CPL  = 5'h18;
   localparam logic [4:0] GRP_STC  = 5'h19;
   localparam logic [4:0] GRP_XORC = 5'h1a;
   localparam logic [4:0] GRP_TEST = 5'h1b;

   localparam logic [7:0] LOW_NIBBLE  = 8'h0f;
   localparam logic [7:0] HIGH_NIBBLE = 8'hf0;
   localparam logic [7:0] ALL_ONES    = 8'hff;

   typedef enum logic [3:0] {
      OP_ROLD,
      OP_RORD,
      OP_INC,
      OP_DEC,
      OP_MCMP,
      OP_SET,
      OP_CLR,
      OP_CPL,
      OP_LD,
      OP_XCH,
      OP_STC,
      OP_XORC,
      OP_TEST,
      OP_NONE
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [2:0]  sel;
      logic [15:0] address;
      logic [7:0]  src;
      logic [7:0]  acc;
      logic [7:0]  regv;
      logic [7:0]  imm;
   } item_type;

   typedef struct packed {
      logic        not_handled;
      logic        jump_flag;
      logic        zero_flag;
      logic        carry_flag;
      logic [7:0]  reg_write_data;
      logic [2:0]  reg_index;
      logic        reg_write_enable;
      logic [7:0]  acc_write_data;
      logic        acc_write_enable;
      logic [7:0]  mem_write_data;
      logic [15:0] mem_write_address;
      logic        mem_write_enable;
   } result_type;

endpackage

/* rtl/meu_decode.sv */
module meu_decode
   import meu_pkg::*;
(
   input  logic [55:0] req_tdata,
   output item_type    item
);

   logic [7:0] cmd;
   logic [4:0] grp;
   op_type     op;

   assign cmd = req_tdata[7:0];
   assign grp = cmd[7:3];

   always_comb begin
      op = OP_NONE;
      if (cmd == CMD_ROLD) begin
         op = OP_ROLD;
      end else if (cmd == CMD_RORD) begin
         op = OP_RORD;
      end else if (cmd == CMD_INC) begin
         op = OP_INC;
      end else if (cmd == CMD_DEC) begin
         op = OP_DEC;
      end else if (cmd == CMD_MCMP) begin
         op = OP_MCMP;
      end else begin
         case (grp)
            GRP_SET:  op = OP_SET;
            GRP_CLR:  op = OP_CLR;
            GRP_LD:   op = OP_LD;
            GRP_XCH:  op = OP_XCH;
            GRP_CPL:  op = OP_CPL;
            GRP_STC:  op = OP_STC;
            GRP_XORC: op = OP_XORC;
            GRP_TEST: op = OP_TEST;
            default:  op = OP_NONE;
         endcase
      end
   end

   always_comb begin
      item.op      = op;
      item.sel     = cmd[2:0];
      item.address = req_tdata[23:8];
      item.src     = req_tdata[31:24];
      item.acc     = req_tdata[39:32];
      item.regv    = req_tdata[47:40];
      item.imm     = req_tdata[55:48];
   end

endmodule

/* rtl/meu_queue.sv */
module meu_queue
   import meu_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output logic     not_empty,
   output item_type head
);

   localparam int unsigned PtrWidth = $clog2(QueueDepth);
   localparam int unsigned CntWidth = $clog2(QueueDepth + 1);

   item_type              entry_ff [QueueDepth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]   count_ff, count_in;
   logic                  do_push, do_pop;

   assign full      = (count_ff == CntWidth'(QueueDepth));
   assign not_empty = (count_ff != '0);
   assign head      = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* rtl/meu_execute.sv */
module meu_execute
   import meu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        item_valid,
   input  item_type    item,
   output logic        item_pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output result_type  rsp
);

   logic       carry_ff, carry_in;
   logic       zero_ff, zero_in;
   logic       jump_ff, jump_in;
   logic       valid_ff;
   result_type rsp_ff, rsp_in;
   logic [7:0] mask;
   logic       bit_val;
   logic [7:0] inc_val, dec_val, mcmp_val;

   assign item_pop  = item_valid && (!valid_ff || rsp_ready);
   assign rsp_valid = valid_ff;
   assign rsp       = rsp_ff;

   assign mask     = 8'h01 << item.sel;
   assign bit_val  = item.src[item.sel];
   assign inc_val  = item.src + 8'h01;
   assign dec_val  = item.src + ALL_ONES;
   assign mcmp_val = item.imm & item.src;

   always_comb begin
      carry_in = carry_ff;
      zero_in  = zero_ff;
      jump_in  = jump_ff;

      rsp_in                   = '0;
      rsp_in.mem_write_address = item.address;
      rsp_in.reg_index         = item.sel;

      case (item.op)
         OP_ROLD: begin
            rsp_in.mem_write_enable = 1'b1;
            rsp_in.mem_write_data   = {item.src[3:0], item.acc[3:0]};
            rsp_in.acc_write_enable = 1'b1;
            rsp_in.acc_write_data   = (item.acc & HIGH_NIBBLE) | {4'h0, item.src[7:4]};
         end
         OP_RORD: begin
            rsp_in.mem_write_enable = 1'b1;
            rsp_in.mem_write_data   = {item.acc[3:0], item.src[7:4]};
            rsp_in.acc_write_enable = 1'b1;
            rsp_in.acc_write_data   = (item.acc & HIGH_NIBBLE) | (item.src & LOW_NIBBLE);
         end
         OP_INC: begin
            rsp_in.mem_write_enable = 1'b1;
            rsp_in.mem_write_data   = inc_val;
            zero_in = (inc_val == 8'h00);
            jump_in = (inc_val == 8'h00);
         end
         OP_DEC: begin
            rsp_in.mem_write_enable = 1'b1;
            rsp_in.mem_write_data   = dec_val;
            zero_in = (dec_val == 8'h00);
            jump_in = (dec_val == ALL_ONES);
         end
         OP_MCMP: begin
            zero_in  = (item.acc == mcmp_val);
            jump_in  = (item.acc == mcmp_val);
            carry_in = (item.acc < mcmp_val);
         end
         OP_SET: begin
            rsp_in.mem_write_enable = 1'b1;
            rsp_in.mem_write_data   = item.src | mask;
            zero_in = !bit_val;
            jump_in = !bit_val;
         end
         OP_CLR: begin
            rsp_in.mem_write_enable = 1'b1;
            rsp_in.mem_write_data   = item.src & ~mask;
            zero_in = !bit_val;
            jump_in = !bit_val;
         end
         OP_CPL: begin
            rsp_in.mem_write_enable = 1'b1;
            rsp_in.mem_write_data   = item.src ^ mask;
            zero_in = !bit_val;
            jump_in = !bit_val;
         end
         OP_LD: begin
            rsp_in.reg_write_enable = 1'b1;
            rsp_in.reg_write_data   = item.src;
            jump_in = 1'b1;
            zero_in = (item.src == 8'h00);
         end
         OP_XCH: begin
            rsp_in.mem_write_enable = 1'b1;
            rsp_in.mem_write_data   = item.regv;
            rsp_in.reg_write_enable = 1'b1;
            rsp_in.reg_write_data   = item.src;
            jump_in = 1'b1;
            zero_in = (item.src == 8'h00);
         end
         OP_STC: begin
            rsp_in.mem_write_enable = 1'b1;
            rsp_in.mem_write_data   = carry_ff ? (item.src | mask) : (item.src & ~mask);
            jump_in = 1'b1;
         end
         OP_XORC: begin
            carry_in = carry_ff ^ bit_val;
            jump_in  = carry_ff ^ bit_val;
         end
         OP_TEST: begin
            carry_in = bit_val;
            jump_in  = !bit_val;
         end
         default: begin
            rsp_in.not_handled = 1'b1;
         end
      endcase

      rsp_in.carry_flag = carry_in;
      rsp_in.zero_flag  = zero_in;
      rsp_in.jump_flag  = jump_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         carry_ff <= 1'b0;
         zero_ff  <= 1'b0;
         jump_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         if (item_pop) begin
            carry_ff <= carry_in;
            zero_ff  <= zero_in;
            jump_ff  <= jump_in;
            valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (item_pop) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

/* rtl/memory_operand_execute_unit.sv */
// Executes one memory-operand instruction per transaction: nibble rotates, increment,
// decrement, masked compare, register load and exchange, and the single-bit operations,
// keeping the carry, zero and jump flags inside. Every other opcode comes back with
// not_handled set, no writes and the flags unchanged. One transaction is taken every
// cycle while the queue has room; the request is written into a two-entry queue, then the
// execute stage registers the result, which is held until it is taken. The flags are
// registered with each result and are seen by the next instruction. The queue lets the
// request side keep going for two transactions while the response side stalls.
module memory_operand_execute_unit
   import meu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // cmd[7:0], src_address[23:8], src_byte[31:24], acc_value[39:32],
   // reg_value[47:40], imm_byte[55:48]
   input  logic [55:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // mem_write_enable[0], mem_write_address[16:1], mem_write_data[24:17],
   // acc_write_enable[25], acc_write_data[33:26], reg_write_enable[34],
   // reg_index[37:35], reg_write_data[45:38], carry_flag[46], zero_flag[47],
   // jump_flag[48], not_handled[49], zero fill[55:50]
   output logic [55:0] rsp_tdata
);

   item_type   dec_item;
   item_type   head_item;
   logic       queue_full;
   logic       queue_not_empty;
   logic       queue_pop;
   result_type result;

   meu_decode u_decode (
      .req_tdata (req_tdata),
      .item      (dec_item)
   );

   meu_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_tvalid),
      .push_item (dec_item),
      .full      (queue_full),
      .pop       (queue_pop),
      .not_empty (queue_not_empty),
      .head      (head_item)
   );

   assign req_tready = !queue_full;

   meu_execute u_execute (
      .clock      (clock),
      .reset      (reset),
      .item_valid (queue_not_empty),
      .item       (head_item),
      .item_pop   (queue_pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp        (result)
   );

   assign rsp_tdata = {6'b0, result};

endmodule
